FILE: rtl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants, operation codes and controller/datapath interface types
// of the first-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

	// arena geometry
	localparam int ARENA_BYTES = 4096;
	localparam int HDR_BYTES   = 5;
	localparam int ADDR_W      = $clog2(ARENA_BYTES);
	localparam int LEN_W       = ADDR_W;
	localparam int OP_W        = 2;

	// operation codes
	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
	localparam logic [OP_W-1:0] OP_REALLOC = 2'd2;

	// result status codes
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_NOSPACE = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture the input transaction, clear the result
		logic check;     // evaluate the header read out of the RAMs
		logic wr_hdr;    // first write step: front header / used flag
		logic wr_tail;   // second write step: tail header length
		logic free_old;  // clear the used flag of the old block
		logic out_load;  // move the result into the output register
	} ffa_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [OP_W-1:0] in_op;     // operation of the offered transaction
		logic [OP_W-1:0] op;        // operation of the item in progress
		logic            fit;       // current header is free and large enough
		logic            walk_end;  // next header lies beyond the arena
		logic            out_free;  // output register can take a result
	} ffa_sts_t;

endpackage

`default_nettype wire

FILE: rtl/ffa_ram.sv
// ----------------------------------------------------------------------------
// ffa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl
// Controller: sequences the header walk, the header updates, the release of
// the old block and the hand-off of the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ctrl
	import ffa_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire ffa_sts_t sts,
	output ffa_cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_READ    = 3'd1;
	localparam logic [2:0] ST_CHECK   = 3'd2;
	localparam logic [2:0] ST_WR_HDR  = 3'd3;
	localparam logic [2:0] ST_WR_TAIL = 3'd4;
	localparam logic [2:0] ST_RELEASE = 3'd5;
	localparam logic [2:0] ST_DONE    = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	// next state and command decode
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.in_op == OP_ALLOC || sts.in_op == OP_REALLOC) begin
						state_nxt = ST_READ;
					end else if (sts.in_op == OP_FREE) begin
						state_nxt = ST_RELEASE;
					end else begin
						state_nxt = ST_DONE;
					end
				end
			end
			ST_READ: begin
				state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				if (sts.fit) begin
					state_nxt = ST_WR_HDR;
				end else if (sts.walk_end) begin
					state_nxt = ST_DONE;
				end else begin
					state_nxt = ST_READ;
				end
			end
			ST_WR_HDR: begin
				cmd.wr_hdr = 1'b1;
				state_nxt  = ST_WR_TAIL;
			end
			ST_WR_TAIL: begin
				cmd.wr_tail = 1'b1;
				state_nxt   = (sts.op == OP_REALLOC) ? ST_RELEASE : ST_DONE;
			end
			ST_RELEASE: begin
				cmd.free_old = 1'b1;
				state_nxt    = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/ffa_dp.sv
// ----------------------------------------------------------------------------
// ffa_dp
// Datapath: header RAMs, walk pointer, fit and split evaluation, header
// updates and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_dp
	import ffa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [OP_W-1:0]   in_op,
	input  wire logic [LEN_W-1:0]  in_req,
	input  wire logic [ADDR_W-1:0] in_off,
	input  wire ffa_cmd_t          cmd,
	output ffa_sts_t               sts,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output logic                   out_status,
	output logic [ADDR_W-1:0]      out_offset
);

	localparam logic [LEN_W-1:0] LEN0_RST = LEN_W'(ARENA_BYTES - HDR_BYTES);

	// captured transaction
	logic [OP_W-1:0]   op_q;
	logic [LEN_W-1:0]  req_q;
	logic [ADDR_W-1:0] off_q;

	// walk and update state
	logic [ADDR_W-1:0] hdr_q;
	logic [LEN_W-1:0]  len_q;
	logic              split_q;
	logic [ADDR_W:0]   tail_q;
	logic [ADDR_W:0]   tgt_q;

	// result
	logic              res_status_q;
	logic [ADDR_W-1:0] res_off_q;
	logic              out_valid_q;
	logic              out_status_q;
	logic [ADDR_W-1:0] out_off_q;

	// entry zero has a defined reset value until first written
	logic              used0_vld_q;
	logic              len0_vld_q;

	// RAM ports
	logic              used_we;
	logic [ADDR_W-1:0] used_waddr;
	logic              used_wdata;
	logic              used_rd;
	logic              len_we;
	logic [ADDR_W-1:0] len_waddr;
	logic [LEN_W-1:0]  len_wdata;
	logic [LEN_W-1:0]  len_rd;

	// header evaluation
	logic              cur_used;
	logic [LEN_W-1:0]  cur_len;
	logic              fit;
	logic              split;
	logic [15:0]       split_lhs;
	logic [15:0]       split_rhs;
	logic [ADDR_W+1:0] hdr_next;
	logic [ADDR_W:0]   tail;
	logic              tgt_ok;
	logic              tail_ok;
	logic              rel_ok;

	ffa_ram #(.WIDTH(1), .DEPTH(ARENA_BYTES)) u_used_ram (
		.clk   (clk),
		.we    (used_we),
		.waddr (used_waddr),
		.wdata (used_wdata),
		.raddr (hdr_q),
		.rdata (used_rd)
	);

	ffa_ram #(.WIDTH(LEN_W), .DEPTH(ARENA_BYTES)) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (len_waddr),
		.wdata (len_wdata),
		.raddr (hdr_q),
		.rdata (len_rd)
	);

	// header read, with the reset value of entry zero
	always_comb begin
		cur_used = (hdr_q == '0 && !used0_vld_q) ? 1'b0 : used_rd;
		cur_len  = (hdr_q == '0 && !len0_vld_q) ? LEN0_RST : len_rd;
	end

	// fit, split guard and next header
	always_comb begin
		fit       = !cur_used && (cur_len >= req_q);
		split_lhs = (16'(cur_len) + 16'(2 * HDR_BYTES)) * 16'd5;
		split_rhs = 16'(req_q) * 16'd6;
		split     = (split_lhs > split_rhs)
		            && ({1'b0, cur_len} >= ({1'b0, req_q} + (LEN_W+1)'(HDR_BYTES)));
		hdr_next  = (ADDR_W+2)'(hdr_q) + (ADDR_W+2)'(cur_len) + (ADDR_W+2)'(HDR_BYTES);
		tail      = (ADDR_W+1)'(hdr_q) + (ADDR_W+1)'(cur_len) - (ADDR_W+1)'(req_q);
	end

	assign tgt_ok  = (tgt_q < (ADDR_W+1)'(ARENA_BYTES));
	assign tail_ok = (tail_q < (ADDR_W+1)'(ARENA_BYTES));
	assign rel_ok  = (off_q >= ADDR_W'(HDR_BYTES));

	// RAM write steering
	always_comb begin
		used_we    = 1'b0;
		used_waddr = tgt_q[ADDR_W-1:0];
		used_wdata = 1'b1;
		len_we     = 1'b0;
		len_waddr  = hdr_q;
		len_wdata  = len_q;
		if (cmd.wr_hdr) begin
			used_we   = tgt_ok;
			len_we    = split_q;
		end else if (cmd.wr_tail) begin
			len_we    = split_q && tail_ok;
			len_waddr = tail_q[ADDR_W-1:0];
			len_wdata = req_q;
		end else if (cmd.free_old) begin
			used_we    = rel_ok;
			used_waddr = off_q - ADDR_W'(HDR_BYTES);
			used_wdata = 1'b0;
		end
	end

	// payload registers of the walk
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_op;
			req_q <= in_req;
			off_q <= in_off;
		end
		if (cmd.check && fit) begin
			len_q   <= cur_len - req_q - LEN_W'(HDR_BYTES);
			split_q <= split;
			tail_q  <= tail;
			tgt_q   <= split ? tail : (ADDR_W+1)'(hdr_q);
		end
	end

	// walk pointer, result and entry-zero tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q        <= '0;
			res_status_q <= STATUS_OK;
			res_off_q    <= '0;
			used0_vld_q  <= 1'b0;
			len0_vld_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				hdr_q        <= '0;
				res_status_q <= STATUS_OK;
				res_off_q    <= '0;
			end else if (cmd.check) begin
				if (fit) begin
					res_off_q <= split ? ADDR_W'(tail + (ADDR_W+1)'(HDR_BYTES))
					                   : hdr_q + ADDR_W'(HDR_BYTES);
				end else if (hdr_next >= (ADDR_W+2)'(ARENA_BYTES)) begin
					res_status_q <= STATUS_NOSPACE;
				end else begin
					hdr_q <= hdr_next[ADDR_W-1:0];
				end
			end
			if (used_we && used_waddr == '0) begin
				used0_vld_q <= 1'b1;
			end
			if (len_we && len_waddr == '0) begin
				len0_vld_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_off_q    <= res_off_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_offset = out_off_q;

	// status to the controller
	always_comb begin
		sts.in_op    = in_op;
		sts.op       = op_q;
		sts.fit      = fit;
		sts.walk_end = (hdr_next >= (ADDR_W+2)'(ARENA_BYTES));
		sts.out_free = !out_valid_q || out_ready;
	end

endmodule

`default_nettype wire

FILE: rtl/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator for a 4096-byte arena tiled by headered blocks.
// ----------------------------------------------------------------------------
// Usage:
//   An operation enters on the s_axis channel (operation in tuser, request
//   size and block offset in tdata) and one result leaves on the m_axis
//   channel (status in tuser, data offset in tdata) for every transaction.
//   Allocate walks block headers from offset 0, reading each header visited
//   from the header RAMs and then evaluating it. A granted allocate then
//   writes the front header and used flag, then the tail header length,
//   and hands off the result; a refused one hands off the result directly.
//   A granted reallocate also frees the old block before the hand-off.
//   Free releases the block and then hands off; the unused code only hands off.
//   One item is in work at a time; s_axis_tready is high only while idle.
//   The result sits in an output register, so the next transaction is taken
//   as soon as the result is registered, even while the receiver stalls;
//   a second result waits in the controller until the first is taken.
//   Reset leaves the arena as one free block of 4091 bytes at offset 0 and
//   takes effect at once; no clearing pass is run.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator
	import ffa_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // [11:0] request_size, [23:12] block_offset
	input  wire logic [1:0]  s_axis_tuser,   // [1:0] operation
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // [11:0] data_offset, [15:12] zero
	output logic             m_axis_tuser    // [0] status
);

	ffa_cmd_t          cmd;
	ffa_sts_t          sts;
	logic [ADDR_W-1:0] out_offset;

	ffa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffa_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_op      (s_axis_tuser),
		.in_req     (s_axis_tdata[11:0]),
		.in_off     (s_axis_tdata[23:12]),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_status (m_axis_tuser),
		.out_offset (out_offset)
	);

	assign m_axis_tdata = {4'd0, out_offset};

	// one item in work at a time
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("new transaction taken while an item is in work");

	// a failed allocation reports offset zero
	a_fail_offset: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == STATUS_NOSPACE |-> m_axis_tdata == 16'd0)
		else $error("no-space result with nonzero offset");

	// a granted offset lies past its header
	a_grant_offset: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata != 16'd0 |-> m_axis_tdata >= 16'(HDR_BYTES))
		else $error("granted offset inside the first header");

endmodule

`default_nettype wire
